FILE: rtl/kvm_pkg.sv
`default_nettype none

package kvm_pkg;

  // Default number of entries in the map
  localparam int unsigned KVM_CAPACITY = 64;

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned TOTAL_W = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_REMOVE = 2'd2
  } kvm_kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_ACT
  } kvm_state_e;

  // One stored entry: valid flag, key and value in one memory word
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } kvm_entry_t;

  // Control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic probe;
  } kvm_match_ctl_t;

  // Status from the compare unit back to the sequencer
  typedef struct packed {
    logic hit;
    logic has_free;
  } kvm_match_sts_t;

endpackage : kvm_pkg

`default_nettype wire

FILE: rtl/kvm_store.sv
`default_nettype none

module kvm_store
  import kvm_pkg::*;
#(
  parameter int unsigned CAPACITY = KVM_CAPACITY,
  localparam int unsigned IW      = $clog2(CAPACITY)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [IW-1:0] waddr_i,
  input  wire kvm_entry_t    wdata_i,
  input  wire logic          re_i,
  input  wire logic [IW-1:0] raddr_i,
  output kvm_entry_t         rdata_o
);

  kvm_entry_t mem_q [CAPACITY];
  kvm_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : kvm_store

`default_nettype wire

FILE: rtl/kvm_match.sv
`default_nettype none

module kvm_match
  import kvm_pkg::*;
#(
  parameter int unsigned CAPACITY = KVM_CAPACITY,
  localparam int unsigned IW      = $clog2(CAPACITY)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire kvm_match_ctl_t      ctl_i,
  input  wire logic [KEY_W-1:0]    key_i,
  input  wire logic [IW-1:0]       idx_i,
  input  wire kvm_entry_t          entry_i,
  output kvm_match_sts_t           sts_o,
  output logic [IW-1:0]            hit_idx_o,
  output logic [VALUE_W-1:0]       hit_value_o,
  output logic [IW-1:0]            free_idx_o
);

  logic               hit_q, hit_d;
  logic               free_q, free_d;
  logic [IW-1:0]      hit_idx_q, free_idx_q;
  logic [VALUE_W-1:0] hit_value_q;
  logic               key_eq;
  logic               take_hit, take_free;

  // Shared key comparator, one entry per cycle
  assign key_eq    = (entry_i.key == key_i);
  assign take_hit  = ctl_i.probe && entry_i.valid && key_eq && !hit_q;
  assign take_free = ctl_i.probe && !entry_i.valid && !free_q;

  always_comb begin
    hit_d  = hit_q;
    free_d = free_q;
    if (ctl_i.clear) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else begin
      if (take_hit) begin
        hit_d = 1'b1;
      end
      if (take_free) begin
        free_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      hit_q  <= hit_d;
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_hit && !ctl_i.clear) begin
      hit_idx_q   <= idx_i;
      hit_value_q <= entry_i.value;
    end
    if (take_free && !ctl_i.clear) begin
      free_idx_q <= idx_i;
    end
  end

  assign sts_o.hit      = hit_q;
  assign sts_o.has_free = free_q;
  assign hit_idx_o      = hit_idx_q;
  assign hit_value_o    = hit_value_q;
  assign free_idx_o     = free_idx_q;

endmodule : kvm_match

`default_nettype wire

FILE: rtl/key_value_map_core.sv
`default_nettype none

// Key-to-value map of CAPACITY entries, searched by a single key comparator.
//
// Command channel: present kind_i, key_i and value_i with start_i high; the
// word is taken at a rising edge where busy_o is low. kind_i selects put
// (insert or update), get, or remove; an unused kind changes no entry.
// Result channel: done_o pulses for exactly one cycle with read_value_o,
// found_o, status_o and entry_total_o. The receiver cannot stall, so the
// result must be captured in that cycle.
// Operation: the entry memory is read one word per cycle over all CAPACITY
// entries, then ST_LAST drains the last compare and ST_ACT writes back and
// loads the result. done_o rises as ST_ACT ends, and busy_o drops in that
// same cycle, so the next word can be taken at the edge that ends it; no
// new word is taken while a search is in progress.
// Reset: after rst_ni releases, a clearing pass writes every entry invalid,
// one entry per cycle, with busy_o high. entry_total_o reports the low
// seven bits of the entry count.
module key_value_map_core
  import kvm_pkg::*;
#(
  parameter int unsigned CAPACITY = KVM_CAPACITY
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [KIND_W-1:0]  kind_i,
  input  wire logic [KEY_W-1:0]   key_i,
  input  wire logic [VALUE_W-1:0] value_i,
  output logic                    done_o,
  output logic [VALUE_W-1:0]      read_value_o,
  output logic                    found_o,
  output logic                    status_o,
  output logic [TOTAL_W-1:0]      entry_total_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  kvm_state_e state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] count_q, count_d;

  // Latched command word
  logic [KIND_W-1:0]  kind_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] value_q;
  logic               take_cmd;

  // Probe pipeline: the memory read returns in the cycle after the address
  logic          prb_vld_q;
  logic [IW-1:0] prb_idx_q;

  // Memory port
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr;
  kvm_entry_t    mem_wdata, mem_rdata;

  // Compare unit
  kvm_match_ctl_t     mctl;
  kvm_match_sts_t     msts;
  logic [IW-1:0]      hit_idx, free_idx;
  logic [VALUE_W-1:0] hit_value;

  // Result registers
  logic               done_q;
  logic               resp_load;
  logic [VALUE_W-1:0] rv_d, rv_q;
  logic               found_d, found_q;
  logic               status_d, status_q;
  logic [CW+TOTAL_W-1:0] total_ext;

  kvm_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (cnt_q),
    .rdata_o (mem_rdata)
  );

  kvm_match #(
    .CAPACITY (CAPACITY)
  ) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (mctl),
    .key_i       (key_q),
    .idx_i       (prb_idx_q),
    .entry_i     (mem_rdata),
    .sts_o       (msts),
    .hit_idx_o   (hit_idx),
    .hit_value_o (hit_value),
    .free_idx_o  (free_idx)
  );

  // Sequencer: next state, memory control and result decision
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    count_d    = count_q;
    take_cmd   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = cnt_q;
    mem_wdata  = '0;
    mctl.clear = 1'b0;
    mctl.probe = prb_vld_q;
    resp_load  = 1'b0;
    rv_d       = '0;
    found_d    = 1'b0;
    status_d   = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        // Invalidate one entry per cycle after reset
        mem_we = 1'b1;
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          take_cmd   = 1'b1;
          mctl.clear = 1'b1;
          cnt_d      = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle across the whole table
        mem_re = 1'b1;
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = ST_LAST;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_LAST: begin
        // Let the final entry reach the comparator
        state_d = ST_ACT;
      end
      ST_ACT: begin
        resp_load       = 1'b1;
        found_d         = msts.hit;
        mem_wdata.valid = 1'b1;
        mem_wdata.key   = key_q;
        mem_wdata.value = value_q;
        case (kind_q)
          KIND_PUT: begin
            if (msts.hit) begin
              mem_we    = 1'b1;
              mem_waddr = hit_idx;
            end else if (msts.has_free) begin
              mem_we    = 1'b1;
              mem_waddr = free_idx;
              count_d   = count_q + 1'b1;
            end else begin
              status_d = 1'b1;
            end
          end
          KIND_GET: begin
            if (msts.hit) begin
              rv_d = hit_value;
            end
          end
          KIND_REMOVE: begin
            if (msts.hit) begin
              mem_we          = 1'b1;
              mem_waddr       = hit_idx;
              mem_wdata.valid = 1'b0;
              count_d         = count_q - 1'b1;
            end
          end
          default: begin
            // Unused kind: report the count, touch nothing
            found_d = 1'b0;
          end
        endcase
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      count_q   <= '0;
      prb_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      count_q   <= count_d;
      prb_vld_q <= (state_q == ST_SCAN);
      done_q    <= resp_load;
    end
  end

  // Payload registers: hold the probe index, the command word and the result
  always_ff @(posedge clk_i) begin
    prb_idx_q <= cnt_q;
    if (take_cmd) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (resp_load) begin
      rv_q     <= rv_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  assign total_ext = {{TOTAL_W{1'b0}}, count_q};

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign read_value_o  = rv_q;
  assign found_o       = found_q;
  assign status_o      = status_q;
  assign entry_total_o = total_ext[TOTAL_W-1:0];

endmodule : key_value_map_core

`default_nettype wire
